[sv/swam_pkg.sv]
// Shared types, constants and helpers for the sliding-window anagram match unit.
`timescale 1ns / 1ps

package swam_pkg;

    localparam int WINDOW_MAX    = 256;
    localparam int ALPHABET_SIZE = 256;

    localparam int SYM_W = 8;
    localparam int CNT_W = 10;
    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int NZ_W  = $clog2(ALPHABET_SIZE + 1);
    localparam int POS_W = 32;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;

    // Count-table update carried from the front stage to the table stage.
    typedef struct packed {
        logic             valid;
        logic             clear;
        logic             a_en;
        logic             a_inc;
        logic             b_en;
        logic [SYM_W-1:0] sym;
        logic             text;
        logic             full;
        logic [POS_W-1:0] start;
        logic             overflow;
    } upd_t;

    typedef struct packed {
        logic             valid;
        logic             full;
        logic             match;
        logic [POS_W-1:0] start;
        logic             overflow;
    } res_t;

    function automatic logic [SYM_W-1:0] sym_clamp(input logic [SYM_W-1:0] s);
        logic [SYM_W:0] top;
        top = (SYM_W + 1)'(ALPHABET_SIZE);
        return ({1'b0, s} >= top) ? SYM_W'(ALPHABET_SIZE - 1) : s;
    endfunction

endpackage

[sv/swam_front.sv]
// Front stage: command decode, window bookkeeping and the window byte memory.
`timescale 1ns / 1ps

module swam_front import swam_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic             adv,
    input  logic [1:0]       cmd,
    input  logic [SYM_W-1:0] sym_in,
    output upd_t             upd,
    output logic [SYM_W-1:0] old_sym
);

    logic [SYM_W-1:0] win_mem [WINDOW_MAX];
    logic [SYM_W-1:0] old_sym_reg;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             started_reg, started_next;
    logic             ovf_reg, ovf_next;
    upd_t             upd_reg, upd_next;

    logic [SYM_W-1:0] sym;
    logic [PTR_W-1:0] wp_eff;
    logic [LEN_W-1:0] wp_inc;
    logic [POS_W-1:0] plen_m1;
    logic             evict;
    logic             win_we;

    assign sym     = sym_clamp(sym_in);
    assign wp_eff  = (LEN_W'(wp_reg) >= plen_reg) ? '0 : wp_reg;
    assign wp_inc  = LEN_W'(wp_eff) + LEN_W'(1);
    assign plen_m1 = POS_W'(plen_reg) - POS_W'(1);
    assign evict   = (fill_reg == plen_reg);

    always_comb begin
        wp_next      = wp_reg;
        plen_next    = plen_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        ovf_next     = ovf_reg;
        win_we       = 1'b0;
        upd_next     = '0;
        if (accept) begin
            case (cmd)
                CMD_CLEAR: begin
                    wp_next        = '0;
                    plen_next      = '0;
                    fill_next      = '0;
                    pos_next       = '0;
                    started_next   = 1'b0;
                    ovf_next       = 1'b0;
                    upd_next.valid = 1'b1;
                    upd_next.clear = 1'b1;
                end
                CMD_PATTERN: begin
                    if (!started_reg) begin
                        if (plen_reg < LEN_W'(WINDOW_MAX)) begin
                            plen_next      = plen_reg + LEN_W'(1);
                            upd_next.valid = 1'b1;
                            upd_next.a_en  = 1'b1;
                            upd_next.sym   = sym;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                CMD_TEXT: begin
                    started_next   = 1'b1;
                    pos_next       = (pos_reg == '1) ? pos_reg : pos_reg + POS_W'(1);
                    upd_next.valid = 1'b1;
                    upd_next.text  = 1'b1;
                    upd_next.sym   = sym;
                    if (plen_reg != '0) begin
                        win_we        = 1'b1;
                        upd_next.a_en  = 1'b1;
                        upd_next.a_inc = 1'b1;
                        upd_next.b_en  = evict;
                        if (!evict) begin
                            fill_next = fill_reg + LEN_W'(1);
                        end
                        wp_next = (wp_inc >= plen_reg) ? '0 : wp_inc[PTR_W-1:0];
                        if (fill_next == plen_reg) begin
                            upd_next.full  = 1'b1;
                            upd_next.start = (pos_reg >= plen_m1) ? pos_reg - plen_m1 : '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        upd_next.overflow = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            plen_reg    <= '0;
            fill_reg    <= '0;
            pos_reg     <= '0;
            started_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            upd_reg     <= '0;
        end else begin
            wp_reg      <= wp_next;
            plen_reg    <= plen_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
            ovf_reg     <= ovf_next;
            if (adv) begin
                upd_reg <= upd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            old_sym_reg <= win_mem[wp_eff];
        end
        if (win_we) begin
            win_mem[wp_eff] <= sym;
        end
    end

    assign upd     = upd_reg;
    assign old_sym = old_sym_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= plen_reg)
        else $error("window fill exceeds pattern length");

endmodule

[sv/swam_table.sv]
// Count-difference table: two-port read, modify and write back with forwarding.
`timescale 1ns / 1ps

module swam_table import swam_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  upd_t             upd,
    input  logic [SYM_W-1:0] old_sym,
    output res_t             res
);

    logic signed [CNT_W-1:0] cnt_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] vld_reg;

    upd_t                    s2_reg;
    logic [SYM_W-1:0]        b_addr_reg;
    logic signed [CNT_W-1:0] rd_a_reg, rd_b_reg;
    logic [NZ_W-1:0]         nz_reg, nz_next;

    logic                    fa_vld_reg, fb_vld_reg;
    logic [SYM_W-1:0]        fa_addr_reg, fb_addr_reg;
    logic signed [CNT_W-1:0] fa_data_reg, fb_data_reg;

    logic signed [CNT_W-1:0] a_before, b_before, a_after, b_after;
    logic                    same, we_a, we_b;
    logic                    up_a, up_b, dn_a, dn_b;

    always_comb begin
        a_before = vld_reg[s2_reg.sym] ? rd_a_reg : '0;
        if (fb_vld_reg && fb_addr_reg == s2_reg.sym) begin
            a_before = fb_data_reg;
        end
        if (fa_vld_reg && fa_addr_reg == s2_reg.sym) begin
            a_before = fa_data_reg;
        end
        b_before = vld_reg[b_addr_reg] ? rd_b_reg : '0;
        if (fb_vld_reg && fb_addr_reg == b_addr_reg) begin
            b_before = fb_data_reg;
        end
        if (fa_vld_reg && fa_addr_reg == b_addr_reg) begin
            b_before = fa_data_reg;
        end
    end

    assign a_after = s2_reg.a_inc ? a_before + CNT_W'(1) : a_before - CNT_W'(1);
    assign b_after = b_before - CNT_W'(1);
    assign same    = s2_reg.a_en && s2_reg.b_en && (s2_reg.sym == b_addr_reg);
    assign we_a    = s2_reg.valid && !s2_reg.clear && s2_reg.a_en && !same;
    assign we_b    = s2_reg.valid && !s2_reg.clear && s2_reg.b_en && !same;
    assign up_a    = we_a && (a_before == '0) && (a_after != '0);
    assign dn_a    = we_a && (a_before != '0) && (a_after == '0);
    assign up_b    = we_b && (b_before == '0) && (b_after != '0);
    assign dn_b    = we_b && (b_before != '0) && (b_after == '0);
    assign nz_next = nz_reg + NZ_W'(up_a) + NZ_W'(up_b) - NZ_W'(dn_a) - NZ_W'(dn_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            nz_reg     <= '0;
            s2_reg     <= '0;
            fa_vld_reg <= 1'b0;
            fb_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_reg     <= upd;
            fa_vld_reg <= we_a;
            fb_vld_reg <= we_b;
            if (s2_reg.valid && s2_reg.clear) begin
                vld_reg <= '0;
                nz_reg  <= '0;
            end else begin
                nz_reg <= nz_next;
                if (we_a) begin
                    vld_reg[s2_reg.sym] <= 1'b1;
                end
                if (we_b) begin
                    vld_reg[b_addr_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_a_reg    <= cnt_mem[upd.sym];
            rd_b_reg    <= cnt_mem[old_sym];
            b_addr_reg  <= old_sym;
            fa_addr_reg <= s2_reg.sym;
            fa_data_reg <= a_after;
            fb_addr_reg <= b_addr_reg;
            fb_data_reg <= b_after;
            if (we_a) begin
                cnt_mem[s2_reg.sym] <= a_after;
            end
            if (we_b) begin
                cnt_mem[b_addr_reg] <= b_after;
            end
        end
    end

    assign res.valid    = s2_reg.valid && s2_reg.text;
    assign res.full     = s2_reg.full;
    assign res.match    = s2_reg.full && (nz_next == '0);
    assign res.start    = s2_reg.start;
    assign res.overflow = s2_reg.overflow;

    a_nz_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nz_reg <= NZ_W'(ALPHABET_SIZE))
        else $error("nonzero symbol count out of range");

    a_fwd_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (fa_vld_reg && fb_vld_reg) |-> (fa_addr_reg != fb_addr_reg))
        else $error("forwarded writes hit the same table entry");

endmodule

[sv/sliding_window_anagram_match_unit.sv]
// Top level of the sliding-window anagram match unit with the result register.
//
// Send a clear transfer (tuser 0), then pattern bytes (tuser 1), then text
// bytes (tuser 2) with the byte in tdata. Each text byte gives one result:
// window full, anagram found, window start offset (saturating) and the
// pattern overflow flag; clear and pattern transfers give none. The unit
// takes one transfer per cycle unless the input stalls. Each result goes
// through a read of the window byte memory, a read of the count table at
// two ports, then the table update and write back, which loads the output
// register, with forwarding between adjacent bytes. The count table is
// cleared at once by reset or a clear transfer through per-entry valid
// bits, so there is no clearing pass. Input stalls only while a text
// result is waiting in the last stage behind an untaken output.
`timescale 1ns / 1ps

module sliding_window_anagram_match_unit import swam_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] window_full, [1] anagram_found,
                                   // [33:2] start_offset, [34] pattern_overflow
);

    upd_t             upd;
    res_t             res;
    logic [SYM_W-1:0] old_sym;
    logic             adv, accept;

    logic             out_vld_reg;
    res_t             out_reg;

    assign adv      = !(res.valid && out_vld_reg && !m_tready);
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    swam_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .adv     (adv),
        .cmd     (s_tuser),
        .sym_in  (s_tdata),
        .upd     (upd),
        .old_sym (old_sym)
    );

    swam_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .upd     (upd),
        .old_sym (old_sym),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv && res.valid) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_reg.overflow, out_reg.start, out_reg.match, out_reg.full};

    a_match_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
        else $error("anagram reported on a partial window");

    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[33:2] == 32'd0))
        else $error("start offset set on a partial window");

endmodule
